// ===== rtl/core/rbps_pkg.sv =====
`default_nettype none

package rbps_pkg;

    // Window depth and position counter size
    localparam int MAX_PATTERN   = 8;
    localparam int POSITION_BITS = 32;

    // Derived widths
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W  = 4;
    localparam int PAT_W  = 8 * MAX_PATTERN;
    localparam int MPOS_W = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_BYTES  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LENGTH = CFG_ADDR_W'(1);

    localparam logic [POSITION_BITS-1:0] POS_TOP = '1;

    typedef logic [7:0] t_byte;

    // Clamp the configured length into 1..MAX_PATTERN
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_PATTERN)) begin
            n = LEN_W'(MAX_PATTERN);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/relative_byte_pattern_search_unit.sv =====
`default_nettype none

// Relative byte pattern search. Content bytes arrive one per input beat; the
// unit keeps the latest MAX_PATTERN bytes and reports every window that equals
// the configured pattern plus one common offset (mod 256), giving the start
// index of the window and the offset, in stream order. A beat with
// start_of_content set clears the window and restarts indexing at zero; the
// index saturates at its top value. One byte is taken every clock: the shift
// window, the eight byte subtract-compares and the output register form a
// single stage, so the only hold-off is a stalled, full output register.
// Write pattern_bytes (index 0) and pattern_length (index 1) only while idle.
module relative_byte_pattern_search_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration
    input  wire                                   i_cfg_we,
    input  wire  [rbps_pkg::CFG_ADDR_W-1:0]       i_cfg_index,
    input  wire  [rbps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  [7:0]                            i_data_byte,
    input  wire                                   i_start_of_content,
    // output channel
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [rbps_pkg::MPOS_W-1:0]           o_match_position,
    output logic [7:0]                            o_match_offset
);
    import rbps_pkg::*;

    logic [PAT_W-1:0]         r_pattern;
    logic [LEN_W-1:0]         r_length;
    t_byte                    r_win [MAX_PATTERN];
    t_byte                    n_win [MAX_PATTERN];
    logic [FILL_W-1:0]        r_fill;
    logic [FILL_W-1:0]        n_fill;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] here;
    logic                     r_out_vld;
    logic [MPOS_W-1:0]        r_mpos;
    logic [MPOS_W-1:0]        n_mpos;
    t_byte                    r_moff;
    t_byte                    n_moff;
    logic                     in_acc;
    logic                     hit;
    logic [LEN_W-1:0]         len;
    logic [IDX_W-1:0]         len_m1;
    logic [FILL_W-1:0]        fill_base;
    logic [IDX_W-1:0]         idx;
    t_byte                    diff;

    // Hold input while the result register is full and stalled
    assign o_in_stall = r_out_vld & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PATTERN_BYTES) begin
                r_pattern <= PAT_W'(i_cfg_data);
            end else if (i_cfg_index == CFG_PATTERN_LENGTH) begin
                r_length <= i_cfg_data[LEN_W-1:0];
            end
        end
    end

    // Shift the new byte into the window, advance fill and position
    always_comb begin
        n_win[0] = i_data_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_win[i] = i_start_of_content ? 8'h00 : r_win[i-1];
        end
        fill_base = i_start_of_content ? '0 : r_fill;
        n_fill    = (fill_base < FILL_W'(MAX_PATTERN)) ? fill_base + FILL_W'(1) : fill_base;
        here      = i_start_of_content ? '0 : r_pos;
        n_pos     = (here < POS_TOP) ? here + POSITION_BITS'(1) : here;
    end

    // Compare every window byte against its pattern byte under one offset
    always_comb begin
        len    = eff_length(r_length);
        len_m1 = IDX_W'(len - LEN_W'(1));
        n_moff = n_win[len_m1] - r_pattern[7:0];
        hit    = (FILL_W'(len) <= n_fill);
        for (int i = 1; i < MAX_PATTERN; i++) begin
            idx  = len_m1 - IDX_W'(i);
            diff = n_win[idx] - r_pattern[8*i +: 8];
            if ((i < int'(len)) && (diff != n_moff)) begin
                hit = 1'b0;
            end
        end
        n_mpos = MPOS_W'(here - POSITION_BITS'(len_m1));
    end

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= 8'h00;
            end
        end else if (in_acc) begin
            r_fill <= n_fill;
            r_pos  <= n_pos;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // Result register: load on a hit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_acc) begin
            r_out_vld <= hit;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && hit) begin
            r_mpos <= n_mpos;
            r_moff <= n_moff;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_match_position = r_mpos;
    assign o_match_offset   = r_moff;

`ifndef NO_ASSERTIONS
    // Fill count never passes the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_PATTERN))
        else $error("fill count above window depth");

    // A start beat restarts indexing at one byte in
    a_start_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_start_of_content |=> (r_pos == POSITION_BITS'(1)) && (r_fill == FILL_W'(1)))
        else $error("start beat did not restart the window");

    // Position advances by one per accepted byte until it saturates
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_start_of_content && (r_pos != POS_TOP)
        |=> r_pos == $past(r_pos) + POSITION_BITS'(1))
        else $error("position did not advance");

    // A full, stalled result register blocks the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !in_acc)
        else $error("input taken while result held");
`endif

endmodule

`default_nettype wire

// ===== tb/relative_byte_pattern_search_unit_tb.sv =====
module relative_byte_pattern_search_unit_tb;
    import rbps_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SEGMENT_ITEMS = 58;

    // Indexes past the last register; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_2 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_3 = CFG_ADDR_W'(3);

    typedef struct packed {
        logic [MPOS_W-1:0] position;
        t_byte             offset;
    } t_search_hit;

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  i_cfg_we           = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data         = '0;
    logic                  i_in_valid         = 1'b0;
    logic                  o_in_stall;
    t_byte                 i_data_byte        = '0;
    logic                  i_start_of_content = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall        = 1'b0;
    logic [MPOS_W-1:0]     o_match_position;
    t_byte                 o_match_offset;

    int send_idle_pct = 11;
    int stall_pct     = 56;
    int fail_count    = 0;

    // Shadow of the search state and registers
    logic [PAT_W-1:0]         search_pattern = '0;
    logic [LEN_W-1:0]         search_length  = LEN_W'(1);
    t_byte                    srch_window [MAX_PATTERN] = '{default: '0};
    int                       srch_fill = 0;
    logic [POSITION_BITS-1:0] srch_pos  = '0;

    t_search_hit expected_hits [$];

    relative_byte_pattern_search_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_start_of_content (i_start_of_content),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_match_position   (o_match_position),
        .o_match_offset     (o_match_offset)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    // Clamp the configured length into 1..MAX_PATTERN
    function automatic int active_length();
        int n;
        n = int'(search_length);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_PATTERN) begin
            n = MAX_PATTERN;
        end
        return n;
    endfunction

    // Shift one byte into the shadow window and queue the match it completes
    task automatic predict_search_step(input t_byte value, input logic soc);
        int                       len;
        int                       k;
        logic [POSITION_BITS-1:0] here;
        t_byte                    offset;
        bit                       hit;
        t_search_hit              m;
        if (soc) begin
            for (k = 0; k < MAX_PATTERN; k++) begin
                srch_window[k] = '0;
            end
            srch_fill = 0;
            srch_pos  = '0;
        end
        for (k = MAX_PATTERN - 1; k > 0; k--) begin
            srch_window[k] = srch_window[k-1];
        end
        srch_window[0] = value;
        if (srch_fill < MAX_PATTERN) begin
            srch_fill++;
        end
        here = srch_pos;
        if (srch_pos != POS_TOP) begin
            srch_pos++;
        end
        len = active_length();
        if (srch_fill >= len) begin
            offset = t_byte'(srch_window[len-1] - search_pattern[7:0]);
            hit = 1'b1;
            for (k = 1; k < len; k++) begin
                if (t_byte'(srch_window[len-1-k] - search_pattern[8*k +: 8]) != offset) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                m.position = MPOS_W'(here - POSITION_BITS'(len - 1));
                m.offset   = offset;
                expected_hits.push_back(m);
            end
        end
    endtask

    // Stall the output at random and check every accepted result beat
    always @(posedge i_clk) begin
        t_search_hit want;
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_hits.size() == 0) begin
                log_failure($sformatf("unexpected match: position %0d offset %02h",
                                      o_match_position, o_match_offset));
            end else begin
                want = expected_hits.pop_front();
                if (o_match_position !== want.position || o_match_offset !== want.offset) begin
                    log_failure($sformatf(
                        "match mismatch: expected position %0d offset %02h, got %0d %02h",
                        want.position, want.offset, o_match_position, o_match_offset));
                end
            end
        end
    end

    // Offer one byte beat, with a random gap first, and hold it until taken
    task automatic send_byte(input t_byte value, input logic soc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_data_byte        <= value;
        i_start_of_content <= soc;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_search_step(value, soc);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (index == CFG_PATTERN_BYTES) begin
            search_pattern = value;
        end else if (index == CFG_PATTERN_LENGTH) begin
            search_length = value[LEN_W-1:0];
        end
    endtask

    // Pause the sender until every queued match is out, then let the pipe settle
    task automatic drain_matches();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_hits.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reset registers: zero pattern, length one, so every byte matches itself
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    // Three-byte pattern with plain and wrapping offsets
    task automatic test_offset_match();
        drain_matches();
        write_register(CFG_PATTERN_BYTES, 64'hDEAD_BEEF_CA30_2010);
        write_register(CFG_PATTERN_LENGTH, 64'h3);
        send_byte(8'h15, 1'b1);
        send_byte(8'h25, 1'b0);
        send_byte(8'h35, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h2F, 1'b0);
    endtask

    // Full-width pattern, then length zero and an oversized length
    task automatic test_length_extremes();
        int k;
        drain_matches();
        write_register(CFG_PATTERN_BYTES, '1);
        write_register(CFG_PATTERN_LENGTH, 64'h8);
        for (k = 0; k < MAX_PATTERN; k++) begin
            send_byte(8'h7F, k == 0);
        end
        drain_matches();
        write_register(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
        send_byte(8'h01, 1'b0);
        drain_matches();
        write_register(CFG_PATTERN_LENGTH, 64'hF);
        send_byte(8'h7F, 1'b0);
    endtask

    // No match until the window holds a full pattern; a new content clears it
    task automatic test_short_window();
        drain_matches();
        write_register(CFG_PATTERN_BYTES, '0);
        write_register(CFG_PATTERN_LENGTH, 64'h4);
        send_byte(8'h33, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b0);
    endtask

    // Shorter length applies to bytes already held; spare indexes change nothing
    task automatic test_midstream_length();
        drain_matches();
        write_register(CFG_PATTERN_LENGTH, 64'h2);
        send_byte(8'h33, 1'b0);
        drain_matches();
        write_register(CFG_SPARE_2, 64'h1);
        write_register(CFG_SPARE_3, '1);
        send_byte(8'h33, 1'b0);
    endtask

    // New registers, then mostly pattern-shaped runs with random offsets
    task automatic run_random_segment(input int n_items, input int fixed_len);
        int                    sent;
        int                    len;
        int                    k;
        int                    spot;
        int                    pick;
        logic [CFG_DATA_W-1:0] pat;
        logic [CFG_DATA_W-1:0] len_word;
        t_byte                 offset;
        t_byte                 b;
        logic                  soc;
        drain_matches();
        case ($urandom_range(3))
            0: begin
                pat = {$urandom, $urandom};
            end
            1: begin
                pat = '0;
            end
            2: begin
                pat = '1;
            end
            default: begin
                b   = t_byte'($urandom_range(255));
                pat = {8{b}};
            end
        endcase
        len_word = {$urandom, $urandom};
        if (fixed_len >= 0) begin
            len_word[3:0] = fixed_len[3:0];
        end else if ($urandom_range(9) < 8) begin
            len_word[3:0] = 4'($urandom_range(1, MAX_PATTERN));
        end else begin
            len_word[3:0] = 4'($urandom_range(15));
        end
        write_register(CFG_PATTERN_BYTES, pat);
        write_register(CFG_PATTERN_LENGTH, len_word);
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len    = active_length();
                offset = t_byte'($urandom_range(255));
                spot   = ($urandom_range(99) < 15) ? $urandom_range(len - 1) : -1;
                soc    = ($urandom_range(9) == 0);
                for (k = 0; k < len; k++) begin
                    b = t_byte'(pat[8*k +: 8] + offset);
                    if (k == spot) begin
                        b = b ^ t_byte'($urandom_range(1, 255));
                    end
                    send_byte(b, soc && k == 0);
                    sent++;
                end
            end else if (pick < 68) begin
                send_byte(t_byte'($urandom_range(255)), 1'b1);
                sent++;
            end else begin
                send_byte(t_byte'($urandom_range(255)), 1'b0);
                sent++;
            end
        end
    endtask

    // Three idle profiles, four register settings each
    task automatic test_random_traffic();
        int phase;
        int seg;
        int s;
        int fixed_len;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 11;
                    stall_pct     = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    stall_pct     = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            for (seg = 0; seg < 4; seg++) begin
                s = phase * 4 + seg;
                case (s)
                    0:       fixed_len = MAX_PATTERN;
                    1:       fixed_len = 1;
                    6:       fixed_len = 0;
                    11:      fixed_len = 15;
                    default: fixed_len = -1;
                endcase
                run_random_segment(SEGMENT_ITEMS, fixed_len);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_offset_match();
        test_length_extremes();
        test_short_window();
        test_midstream_length();
        test_random_traffic();
        drain_matches();
        if (expected_hits.size() != 0) begin
            log_failure($sformatf("%0d expected matches never arrived", expected_hits.size()));
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
